// ----- hdl/tta_pkg.sv -----
// ----------------------------------------------------------------------------
// tta_pkg
// Shared widths, reset values, register codes and types for the tap tempo
// averager.
// ----------------------------------------------------------------------------
package tta_pkg;

	localparam int HISTORY_DEPTH_DEF = 4;

	localparam int TICK_W   = 16;
	localparam int PERIOD_W = 11;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [TICK_W-1:0]   RESTART_LIMIT_RST = 16'd3000;
	localparam logic [PERIOD_W-1:0] MAX_INTERVAL_RST  = 11'd1172;

	// register index codes, taken from paddr[2]
	localparam logic REG_RESTART_LIMIT = 1'b0;
	localparam logic REG_MAX_INTERVAL  = 1'b1;

	typedef struct packed {
		logic [TICK_W-1:0]   restart_limit;
		logic [PERIOD_W-1:0] max_interval;
	} cfg_t;

endpackage

// ----- hdl/tta_if.sv -----
// ----------------------------------------------------------------------------
// tta_if
// Valid/ready channels for tap events and averaged period results.
// ----------------------------------------------------------------------------
interface tta_tap_if;
	logic                      valid;
	logic                      ready;
	logic [tta_pkg::TICK_W-1:0] elapsed_ticks;

	modport source (output valid, output elapsed_ticks, input ready);
	modport sink   (input valid, input elapsed_ticks, output ready);
endinterface

interface tta_result_if;
	logic                        valid;
	logic                        ready;
	logic [tta_pkg::PERIOD_W-1:0] period;
	logic                        updated;

	modport source (output valid, output period, output updated, input ready);
	modport sink   (input valid, input period, input updated, output ready);
endinterface

// ----- hdl/tta_regs.sv -----
// ----------------------------------------------------------------------------
// tta_regs
// APB-style configuration registers: restart limit and maximum interval.
// ----------------------------------------------------------------------------
module tta_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tta_pkg::APB_AW-1:0] paddr,
	input  logic [tta_pkg::APB_DW-1:0] pwdata,
	output logic [tta_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output tta_pkg::cfg_t              cfg
);
	import tta_pkg::*;

	logic [TICK_W-1:0]   restart_limit_q;
	logic [PERIOD_W-1:0] max_interval_q;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_limit_q <= RESTART_LIMIT_RST;
			max_interval_q  <= MAX_INTERVAL_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_RESTART_LIMIT: restart_limit_q <= pwdata[TICK_W-1:0];
				REG_MAX_INTERVAL:  max_interval_q  <= pwdata[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_RESTART_LIMIT: prdata = {{(APB_DW-TICK_W){1'b0}}, restart_limit_q};
			REG_MAX_INTERVAL:  prdata = {{(APB_DW-PERIOD_W){1'b0}}, max_interval_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg.restart_limit = restart_limit_q;
	assign cfg.max_interval  = max_interval_q;

endmodule

// ----- hdl/tta_div.sv -----
// ----------------------------------------------------------------------------
// tta_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tta_div #(
	parameter int TOTAL_W = 13,
	parameter int CNT_W   = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [TOTAL_W-1:0] dividend,
	input  logic [CNT_W-1:0]   divisor,
	output logic               done,
	output logic [TOTAL_W-1:0] quotient
);
	localparam int STEP_W = $clog2(TOTAL_W + 1);

	logic [TOTAL_W-1:0] quo_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   dvs_q;
	logic [STEP_W-1:0]  step_q;
	logic               done_q;
	logic [CNT_W:0]     trial;
	logic [CNT_W:0]     diff;
	logic               fits;

	assign trial = {rem_q, quo_q[TOTAL_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= STEP_W'(TOTAL_W);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (step_q != '0) begin
			if (fits) begin
				rem_q <= diff[CNT_W-1:0];
			end else begin
				rem_q <= trial[CNT_W-1:0];
			end
			quo_q <= {quo_q[TOTAL_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- hdl/tap_tempo_averager_unit.sv -----
// ----------------------------------------------------------------------------
// tap_tempo_averager_unit
// Tap tempo period estimator: moving mean of the last few tap intervals.
// ----------------------------------------------------------------------------
// Usage:
//   tap    : valid/ready sink, one transaction per tap with elapsed_ticks.
//   result : valid/ready source, one transaction per tap with the averaged
//            period and updated (0 when the tap restarted the history).
//   APB    : restart_limit at 0x0, max_interval at 0x4; write while idle.
// Timing: the history and total update in the cycle a tap is taken, then
//   the restoring divider runs one bit per cycle over the total width
//   (13 bits at the default depth); the quotient goes to the pending result
//   register and moves into the output register once that is free; as it
//   moves, the sequencer returns to idle and can take the next tap. A restart
//   tap skips the divider and goes straight to the hold state, where its
//   result waits for the output register. tap.ready is high only while the
//   sequencer is idle.
// Reset: history, total, count and held period go to zero, registers to
//   their reset values; no clearing pass is needed.
// Stall: the result register holds until taken; the next tap may be taken
//   meanwhile, and its result waits until the output register frees up.
// ----------------------------------------------------------------------------
module tap_tempo_averager_unit #(
	parameter int HISTORY_DEPTH = tta_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tta_pkg::APB_AW-1:0] paddr,
	input  logic [tta_pkg::APB_DW-1:0] pwdata,
	output logic [tta_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	tta_tap_if.sink                    tap,
	tta_result_if.source               result
);
	import tta_pkg::*;

	localparam int TOTAL_W = $clog2(HISTORY_DEPTH * ((1 << PERIOD_W) - 1) + 1);
	localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	cfg_t                cfg;
	state_t              state_q;
	logic [PERIOD_W-1:0] hist_q [HISTORY_DEPTH];
	logic [TOTAL_W-1:0]  total_q;
	logic [CNT_W-1:0]    count_q;
	logic [PERIOD_W-1:0] held_q;
	logic [PERIOD_W-1:0] res_period_q;
	logic                res_updated_q;
	logic                out_valid_q;
	logic [PERIOD_W-1:0] out_period_q;
	logic                out_updated_q;
	logic                div_start_q;
	logic                div_done;
	logic [TOTAL_W-1:0]  div_quo;

	logic                tap_acc;
	logic                restart;
	logic [PERIOD_W-1:0] clamped;
	logic                full;
	logic                out_free;

	tta_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tta_div #(
		.TOTAL_W (TOTAL_W),
		.CNT_W   (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (total_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign tap.ready = (state_q == ST_IDLE);
	assign tap_acc   = tap.valid && tap.ready;
	assign restart   = tap.elapsed_ticks >= cfg.restart_limit;
	assign clamped   = (tap.elapsed_ticks > {{(TICK_W-PERIOD_W){1'b0}}, cfg.max_interval})
	                   ? cfg.max_interval : tap.elapsed_ticks[PERIOD_W-1:0];
	assign full      = (count_q == CNT_W'(HISTORY_DEPTH));
	assign out_free  = !out_valid_q || result.ready;

	// sequencer, history and running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			count_q     <= '0;
			held_q      <= '0;
			div_start_q <= 1'b0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (tap_acc) begin
						if (restart) begin
							total_q <= '0;
							count_q <= '0;
							for (int i = 0; i < HISTORY_DEPTH; i++) begin
								hist_q[i] <= '0;
							end
							state_q <= ST_HOLD;
						end else begin
							if (full) begin
								// drop the oldest, shift down, new interval last
								for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
									hist_q[i] <= hist_q[i+1];
								end
								hist_q[HISTORY_DEPTH-1] <= clamped;
								total_q <= total_q - TOTAL_W'(hist_q[0]) + TOTAL_W'(clamped);
							end else begin
								for (int i = 0; i < HISTORY_DEPTH; i++) begin
									if (count_q == CNT_W'(i)) begin
										hist_q[i] <= clamped;
									end
								end
								total_q <= total_q + TOTAL_W'(clamped);
								count_q <= count_q + 1'b1;
							end
							div_start_q <= 1'b1;
							state_q     <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						held_q  <= div_quo[PERIOD_W-1:0];
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// pending result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && tap_acc && restart) begin
			res_period_q  <= held_q;
			res_updated_q <= 1'b0;
		end else if (state_q == ST_DIV && div_done) begin
			res_period_q  <= div_quo[PERIOD_W-1:0];
			res_updated_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_HOLD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD && out_free) begin
			out_period_q  <= res_period_q;
			out_updated_q <= res_updated_q;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.period  = out_period_q;
	assign result.updated = out_updated_q;

endmodule

// ----- hdl/tta_checker.sv -----
// ----------------------------------------------------------------------------
// tta_checker
// Port-level checks for the tap tempo averager, bound to the top level.
// ----------------------------------------------------------------------------
module tta_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         tap_valid,
	input logic                         tap_ready,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [tta_pkg::PERIOD_W-1:0] res_period,
	input logic                         res_updated
);
	// a stalled result holds its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_period) && $stable(res_updated))
		else $error("result changed while stalled");

	// one tap at a time: the sequencer leaves idle after a transaction
	a_tap_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tap_valid && tap_ready |=> !tap_ready)
		else $error("tap taken back to back");

	// ready only drops because a tap was taken
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(tap_ready) |-> $past(tap_valid))
		else $error("tap ready dropped without a transaction");

endmodule

bind tap_tempo_averager_unit tta_checker u_tta_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.tap_valid   (tap.valid),
	.tap_ready   (tap.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_period  (result.period),
	.res_updated (result.updated)
);

// ----- tb/sv/tta_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tta_tb_checker
// Watches the tap, result and APB channels of the tap tempo averager, keeps
// its own copy of the register settings and the interval history, predicts
// the averaged period of every accepted tap and compares each result
// transaction, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module tta_tb_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tta_pkg::APB_AW-1:0] paddr,
	input  logic [tta_pkg::APB_DW-1:0] pwdata,
	input  logic                       pready,
	tta_tap_if                         tap_mon,
	tta_result_if                      res_mon,
	output int unsigned                errors,
	output int unsigned                pending
);
	import tta_pkg::*;

	localparam int DEPTH     = HISTORY_DEPTH_DEF;
	localparam int TOTAL_W   = $clog2(DEPTH * 2047 + 1);
	localparam int COUNT_W   = $clog2(DEPTH + 1);
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int PRINT_CAP = 100;

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic                updated;
	} tempo_t;

	cfg_t                cfg;
	logic [PERIOD_W-1:0] history [DEPTH];
	logic [TOTAL_W-1:0]  total;
	logic [COUNT_W-1:0]  count;
	logic [PERIOD_W-1:0] held;
	tempo_t              expected_tempos [$];

	task automatic report_mismatch(input string msg);
		if (errors < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	// advances the history by one tap and returns the period it reports
	function automatic tempo_t next_tempo(input logic [TICK_W-1:0] ticks);
		logic [PERIOD_W-1:0] kept;
		tempo_t              t;
		// restart test sees the raw interval, before any clamping
		if (ticks >= cfg.restart_limit) begin
			foreach (history[i]) history[i] = '0;
			total = '0;
			count = '0;
			t.period  = held;
			t.updated = 1'b0;
			return t;
		end
		kept = (ticks > cfg.max_interval) ? cfg.max_interval : ticks[PERIOD_W-1:0];
		if (count < DEPTH) begin
			history[IDX_W'(count)] = kept;
			total = total + TOTAL_W'(kept);
			count = count + 1'b1;
		end else begin
			// full: drop the oldest and sum the window again
			for (int i = 0; i < DEPTH - 1; i++) history[i] = history[i + 1];
			history[DEPTH - 1] = kept;
			total = '0;
			foreach (history[i]) total = total + TOTAL_W'(history[i]);
		end
		held = PERIOD_W'(total / count);
		t.period  = held;
		t.updated = 1'b1;
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tempo_t want;
		if (!arst_n) begin
			cfg.restart_limit = RESTART_LIMIT_RST;
			cfg.max_interval  = MAX_INTERVAL_RST;
			foreach (history[i]) history[i] = '0;
			total = '0;
			count = '0;
			held  = '0;
			expected_tempos.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[2])
					REG_RESTART_LIMIT: cfg.restart_limit = pwdata[TICK_W-1:0];
					REG_MAX_INTERVAL:  cfg.max_interval  = pwdata[PERIOD_W-1:0];
					default: ;
				endcase
			end
			// a result is always older than a tap taken at the same edge
			if (res_mon.valid && res_mon.ready) begin
				if (expected_tempos.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: period=%0d updated=%0b",
						res_mon.period, res_mon.updated));
				end else begin
					want = expected_tempos.pop_front();
					if (res_mon.period !== want.period)
						report_mismatch($sformatf("period %0d, expected %0d",
							res_mon.period, want.period));
					if (res_mon.updated !== want.updated)
						report_mismatch($sformatf("updated %0b, expected %0b",
							res_mon.updated, want.updated));
				end
			end
			if (tap_mon.valid && tap_mon.ready)
				expected_tempos.push_back(next_tempo(tap_mon.elapsed_ticks));
			pending = expected_tempos.size();
		end
	end

endmodule

// ----- tb/sv/tb_tap_tempo_averager_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tap_tempo_averager_unit
// Drives taps and register writes into the tap tempo averager, with random
// gaps on the tap side and random back-pressure on the result side; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_tap_tempo_averager_unit;
	import tta_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_TAPS = 950;
	localparam int PHASES      = 6;

	localparam logic [APB_AW-1:0] ADDR_RESTART_LIMIT = {REG_RESTART_LIMIT, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_MAX_INTERVAL  = {REG_MAX_INTERVAL, 2'b00};

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	tta_tap_if    tap ();
	tta_result_if result ();

	int unsigned errors;
	int unsigned pending;
	int unsigned cycle_count;
	bit          gaps_on;

	logic [TICK_W-1:0]   cur_restart;
	logic [PERIOD_W-1:0] cur_max;

	tap_tempo_averager_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.tap     (tap),
		.result  (result)
	);

	tta_tb_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.tap_mon (tap),
		.res_mon (result),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** tap_tempo_averager_unit: FAILED **");
			$finish;
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			result.ready <= !(gaps_on && $urandom_range(0, 99) < 6);
		end
	end

	// called at a falling edge; returns at a falling edge with valid still up,
	// so the caller drives the next value in that same step
	task automatic send_tap(input logic [TICK_W-1:0] ticks);
		while (gaps_on && $urandom_range(0, 99) < 6) begin
			tap.valid <= 1'b0;
			@(negedge clk);
		end
		tap.valid         <= 1'b1;
		tap.elapsed_ticks <= ticks;
		do @(posedge clk); while (!tap.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		tap.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		// let the divider settle before touching registers
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [TICK_W-1:0] restart, input logic [PERIOD_W-1:0] max_iv);
		logic [APB_DW-1:0] word;
		drain();
		// junk in the unused upper bits
		word = $urandom();
		word[TICK_W-1:0] = restart;
		apb_write(ADDR_RESTART_LIMIT, word);
		word = $urandom();
		word[PERIOD_W-1:0] = max_iv;
		apb_write(ADDR_MAX_INTERVAL, word);
		cur_restart = restart;
		cur_max     = max_iv;
	endtask

	// mostly in-window intervals so the history fills, some restarts and noise
	function automatic logic [TICK_W-1:0] pick_ticks();
		int unsigned roll;
		int unsigned top_tick;
		roll = $urandom_range(0, 99);
		if (roll < 8 || cur_restart == 0) return TICK_W'($urandom());
		if (roll < 14) return TICK_W'($urandom_range(cur_restart, 65535));
		top_tick = cur_restart - 1;
		if (roll < 70 && top_tick > 2 * cur_max + 2) top_tick = 2 * cur_max + 2;
		return TICK_W'($urandom_range(0, top_tick));
	endfunction

	initial begin
		logic [TICK_W-1:0]   restart;
		logic [PERIOD_W-1:0] max_iv;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		tap.valid         = 1'b0;
		tap.elapsed_ticks = '0;
		gaps_on           = 1'b1;
		cur_restart       = RESTART_LIMIT_RST;
		cur_max           = MAX_INTERVAL_RST;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: field extremes, clamping, full window, restarts
		send_tap(16'd0);
		send_tap(16'd1);
		send_tap(16'd1172);
		send_tap(16'd1173);
		send_tap(16'd2047);
		send_tap(16'd2999);
		send_tap(16'd3000);
		send_tap(16'hFFFF);
		send_tap(16'd100);
		send_tap(16'd200);
		send_tap(16'd300);

		// zero restart limit: every tap restarts
		set_config(16'd0, 11'd1172);
		send_tap(16'd0);
		send_tap(16'hFFFF);

		// zero max interval: period collapses to zero
		set_config(16'hFFFF, 11'd0);
		send_tap(16'd0);
		send_tap(16'hFFFE);
		send_tap(16'hFFFF);

		// restart limit below max interval
		set_config(16'd500, 11'd2047);
		send_tap(16'd499);
		send_tap(16'd500);
		send_tap(16'd300);

		// widest settings, window full of the largest interval
		set_config(16'hFFFF, 11'd2047);
		repeat (5) send_tap(16'd2047);
		send_tap(16'hFFFE);

		for (int phase = 0; phase < PHASES; phase++) begin
			case ($urandom_range(0, 3))
				0: restart = TICK_W'($urandom_range(1, 65535));
				1: restart = TICK_W'($urandom_range(1, 2500));
				2: restart = 16'hFFFF;
				default: restart = TICK_W'($urandom_range(0, 2));
			endcase
			case ($urandom_range(0, 3))
				0, 1: max_iv = PERIOD_W'($urandom_range(0, 2047));
				2: max_iv = 11'd2047;
				default: max_iv = PERIOD_W'($urandom_range(0, 3));
			endcase
			set_config(restart, max_iv);
			// one phase runs with no gaps or stalls at all
			gaps_on = (phase != 3);
			for (int n = 0; n < RANDOM_TAPS / PHASES; n++) begin
				if ($urandom_range(0, 63) == 0) drain();
				send_tap(pick_ticks());
			end
		end
		gaps_on = 1'b1;

		drain();
		repeat (20) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("** tap_tempo_averager_unit: PASSED **");
		end else begin
			$display("** tap_tempo_averager_unit: FAILED **");
		end
		$finish;
	end

endmodule

// ----- tap_tempo_averager_unit.f -----
hdl/tta_pkg.sv
hdl/tta_if.sv
hdl/tta_regs.sv
hdl/tta_div.sv
hdl/tap_tempo_averager_unit.sv
hdl/tta_checker.sv
tb/sv/tta_checker.sv
tb/sv/tb_tap_tempo_averager_unit.sv
